[rtl/lcfb_pkg.sv]
// Package for the LED cube frame buffer: geometry constants, opcodes and
// the edit command shared by the top level and the layer cells.
// No dependencies.
`default_nettype none

package lcfb_pkg;

  localparam int LAYER_COUNT = 8;
  localparam int STRIP_COUNT = 8;
  localparam int STRIP_BITS  = 8;

  localparam int FUNC_W   = 3;
  localparam int SEL_W    = 3;
  localparam int WORD_W   = 8;
  localparam int ENABLE_W = 8;
  localparam int PASS_W   = 4;

  localparam logic [FUNC_W-1:0] FUNC_REFRESH     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL       = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_LAYER = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SHIFT_UP    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SHIFT_DOWN  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_OR_WORD     = 3'd6;

  typedef logic [STRIP_COUNT-1:0][STRIP_BITS-1:0] layer_words_t;

  typedef struct packed {
    logic              clear_all;
    logic              clear_layer;
    logic              shift_up;
    logic              shift_down;
    logic              wr_pixel;
    logic              pixel_on;
    logic              or_word;
    logic [SEL_W-1:0]  strip_sel;
    logic [SEL_W-1:0]  bit_sel;
    logic [WORD_W-1:0] add_word;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/lcfb_ifs.sv]
// Valid/ready channel interfaces of the LED cube frame buffer: input items,
// strip word results and the draw count register write.
// Depends on lcfb_pkg.
`default_nettype none

interface lcfb_item_if;
  logic                       valid;
  logic                       ready;
  logic [lcfb_pkg::FUNC_W-1:0] func;
  logic [lcfb_pkg::SEL_W-1:0]  layer_sel;
  logic [lcfb_pkg::SEL_W-1:0]  strip_sel;
  logic [lcfb_pkg::SEL_W-1:0]  bit_sel;
  logic                       pixel_on;
  logic [lcfb_pkg::WORD_W-1:0] add_word;

  modport source (output valid, func, layer_sel, strip_sel, bit_sel, pixel_on, add_word,
                  input ready);
  modport sink (input valid, func, layer_sel, strip_sel, bit_sel, pixel_on, add_word,
                output ready);
endinterface

interface lcfb_result_if;
  logic                         valid;
  logic                         ready;
  logic [lcfb_pkg::SEL_W-1:0]    strip_index;
  logic [lcfb_pkg::WORD_W-1:0]   strip_data;
  logic [lcfb_pkg::ENABLE_W-1:0] layer_enable;
  logic                         last;

  modport source (output valid, strip_index, strip_data, layer_enable, last, input ready);
  modport sink (input valid, strip_index, strip_data, layer_enable, last, output ready);
endinterface

interface lcfb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lcfb_pkg::PASS_W-1:0] draws_per_layer;

  modport source (output valid, draws_per_layer, input ready);
  modport sink (input valid, draws_per_layer, output ready);
endinterface

`default_nettype wire

[rtl/lcfb_layer_cell.sv]
// One layer of the cube: STRIP_COUNT strip words, edited in place or
// loaded from the neighbor layer below or above on a shift.
// Depends on lcfb_pkg.
`default_nettype none

module lcfb_layer_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lcfb_pkg::cell_cmd_t      cmd,
  input  wire logic                     hit,
  input  wire lcfb_pkg::layer_words_t   below,
  input  wire lcfb_pkg::layer_words_t   above,
  input  wire logic [lcfb_pkg::SEL_W-1:0] rd_strip,
  output lcfb_pkg::layer_words_t        words,
  output logic [lcfb_pkg::STRIP_BITS-1:0] rd_word
);
  import lcfb_pkg::*;

  assign rd_word = words[rd_strip];

  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
    end else if (cmd.clear_all || (hit && cmd.clear_layer)) begin
      words <= '0;
    end else if (cmd.shift_up) begin
      words <= below;
    end else if (cmd.shift_down) begin
      words <= above;
    end else if (hit) begin
      for (int s = 0; s < STRIP_COUNT; s++) begin
        if (cmd.strip_sel == SEL_W'(s)) begin
          if (cmd.or_word) begin
            words[s] <= words[s] | cmd.add_word[STRIP_BITS-1:0];
          end
          if (cmd.wr_pixel) begin
            for (int b = 0; b < STRIP_BITS; b++) begin
              if (cmd.bit_sel == SEL_W'(b)) begin
                words[s][b] <= cmd.pixel_on;
              end
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/led_cube_frame_buffer_scan.sv]
// Top level of the LED cube frame buffer: a chain of layer cells, the scan
// sequencer and the strip word output register.
// Depends on lcfb_pkg, lcfb_ifs and lcfb_layer_cell.
`default_nettype none

// Holds 8 layers x 8 strips of 8-bit LED words. Edit operations and refresh
// ticks that only advance the scan layer complete on acceptance and leave
// the item port ready. A refresh tick that draws moves one strip word per
// cycle from the scan read mux into the output register unless the result
// sink stalls. No item is taken while a draw is in progress; the next
// item is taken as soon as the last strip word is in the output register.
// The draw count register is always ready and must be written while idle.
module led_cube_frame_buffer_scan (
  input wire logic clk,
  input wire logic rst,
  lcfb_item_if.sink     items,
  lcfb_result_if.source results,
  lcfb_cfg_if.sink      cfg
);
  import lcfb_pkg::*;

  typedef enum logic {S_IDLE, S_DRAW} state_t;

  state_t                    state;
  logic [SEL_W-1:0]          strip_cnt;
  logic [SEL_W-1:0]          scan_layer;
  logic [PASS_W-1:0]         draw_passes;
  logic [PASS_W-1:0]         draws_per_layer;
  logic                      out_valid;
  logic [SEL_W-1:0]          out_index;
  logic [WORD_W-1:0]         out_data;
  logic [ENABLE_W-1:0]       out_enable;
  logic                      out_last;

  logic                      accept;
  logic                      out_load;
  cell_cmd_t                 cmd;
  layer_words_t              cell_words [LAYER_COUNT];
  logic [STRIP_BITS-1:0]     rd_words [LAYER_COUNT];
  logic [LAYER_COUNT-1:0]    hit;

  assign items.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign accept      = items.valid && items.ready;
  assign out_load    = (state == S_DRAW) && (!out_valid || results.ready);

  assign results.valid        = out_valid;
  assign results.strip_index  = out_index;
  assign results.strip_data   = WORD_W'(out_data);
  assign results.layer_enable = out_enable;
  assign results.last         = out_last;

  always_comb begin
    cmd.clear_all   = accept && (items.func == FUNC_CLEAR_ALL);
    cmd.clear_layer = accept && (items.func == FUNC_CLEAR_LAYER);
    cmd.shift_up    = accept && (items.func == FUNC_SHIFT_UP);
    cmd.shift_down  = accept && (items.func == FUNC_SHIFT_DOWN);
    cmd.wr_pixel    = accept && (items.func == FUNC_PIXEL);
    cmd.or_word     = accept && (items.func == FUNC_OR_WORD);
    cmd.pixel_on    = items.pixel_on;
    cmd.strip_sel   = items.strip_sel;
    cmd.bit_sel     = items.bit_sel;
    cmd.add_word    = items.add_word;
  end

  for (genvar l = 0; l < LAYER_COUNT; l++) begin : g_cell
    layer_words_t below;
    layer_words_t above;

    assign hit[l] = (items.layer_sel == SEL_W'(l));

    if (l == 0) begin : g_bottom
      assign below = '0;
    end else begin : g_below
      assign below = cell_words[l-1];
    end

    if (l == LAYER_COUNT - 1) begin : g_top
      assign above = '0;
    end else begin : g_above
      assign above = cell_words[l+1];
    end

    lcfb_layer_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .hit      (hit[l]),
      .below    (below),
      .above    (above),
      .rd_strip (strip_cnt),
      .words    (cell_words[l]),
      .rd_word  (rd_words[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      strip_cnt       <= '0;
      scan_layer      <= '0;
      draw_passes     <= '0;
      draws_per_layer <= PASS_W'(1);
      out_valid       <= 1'b0;
      out_index       <= '0;
      out_data        <= '0;
      out_enable      <= '0;
      out_last        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        draws_per_layer <= cfg.draws_per_layer;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (items.func == FUNC_REFRESH)) begin
            if (draw_passes < draws_per_layer) begin
              draw_passes <= draw_passes + PASS_W'(1);
              strip_cnt   <= '0;
              state       <= S_DRAW;
            end else begin
              draw_passes <= '0;
              scan_layer  <= (scan_layer == SEL_W'(LAYER_COUNT - 1)) ? '0
                                                                    : scan_layer + SEL_W'(1);
            end
          end
        end
        S_DRAW: begin
          if (out_load) begin
            out_index  <= strip_cnt;
            out_data   <= WORD_W'(rd_words[scan_layer]);
            out_enable <= ENABLE_W'(1) << scan_layer;
            out_last   <= (strip_cnt == SEL_W'(STRIP_COUNT - 1));
            if (strip_cnt == SEL_W'(STRIP_COUNT - 1)) begin
              state <= S_IDLE;
            end else begin
              strip_cnt <= strip_cnt + SEL_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/lcfb_checker.sv]
// Port-level checks for the LED cube frame buffer result stream, bound to
// the top level.
// Depends on lcfb_pkg and led_cube_frame_buffer_scan.
`default_nettype none

module lcfb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [lcfb_pkg::SEL_W-1:0]    out_index,
  input wire logic [lcfb_pkg::WORD_W-1:0]   out_data,
  input wire logic [lcfb_pkg::ENABLE_W-1:0] out_enable,
  input wire logic                              out_last
);
  import lcfb_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_data)
      && $stable(out_enable) && $stable(out_last))
    else $error("stalled result beat changed");

  // a layer draw streams without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid
      && out_index == SEL_W'($past(out_index) + SEL_W'(1))
      && out_enable == $past(out_enable))
    else $error("draw burst broken");

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_enable))
    else $error("layer enable not one-hot");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == SEL_W'(STRIP_COUNT - 1))))
    else $error("last flag misplaced");

endmodule

bind led_cube_frame_buffer_scan lcfb_checker u_lcfb_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_index  (results.strip_index),
  .out_data   (results.strip_data),
  .out_enable (results.layer_enable),
  .out_last   (results.last)
);

`default_nettype wire
